// File: hdl/lfkj_pkg.sv
// Shared widths, constants and types of the leg kinematics block.
package lfkj_pkg;

	// Chain and number formats.
	localparam int JOINT_COUNT  = 6;
	localparam int ANGLE_BITS   = 16;
	localparam int UNIT_W       = 32;
	localparam int LEN_W        = 21;
	localparam int LIN_W        = 23;
	localparam int POS_W        = 24;
	localparam int DIF_W        = 25;
	localparam int OP_W         = 33;
	localparam int ACC_W        = 68;
	localparam int RND_W        = ACC_W - 30;
	localparam int CORD_W       = 34;
	localparam int CORDIC_STEPS = 30;
	localparam int JNT_W        = 3;
	localparam int IDX_W        = 2;

	localparam longint ONE_Q30  = 64'sd1 << 30;
	localparam longint HALF_Q30 = 64'sd1 << 29;
	localparam longint LIN_LIMIT = 64'sd1 << 21;
	localparam logic signed [ACC_W-1:0] ONE_Q60 = ACC_W'(1) << 60;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_UPPER = 2'd0;
	localparam logic [IDX_W-1:0] REG_LOWER = 2'd1;

	// Column code of the pose result.
	localparam logic [2:0] POSE_COLUMN = 3'd6;

	typedef logic signed [UNIT_W-1:0] unit_t;
	typedef logic signed [POS_W-1:0]  pos_t;

	// Status of one CORDIC lane.
	typedef struct packed {
		logic busy;
		logic fin;
	} lfkj_cordic_sts_t;

	// Control of one multiply-accumulate lane.
	typedef struct packed {
		logic en;
		logic load;
		logic diag;
	} lfkj_lane_ctl_t;

	// Chain sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AXIS,
		ST_ZCOL,
		ST_OFFS,
		ST_QMUL,
		ST_CROSS,
		ST_POSE
	} lfkj_state_t;

endpackage

// File: hdl/lfkj_cordic.sv
// One iterative CORDIC lane giving the cosine and sine of a half joint angle.
module lfkj_cordic import lfkj_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [ANGLE_BITS-1:0] angle,
	output unit_t                        cos_h,
	output unit_t                        sin_h,
	output lfkj_cordic_sts_t             sts
);

	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
	localparam logic signed [CORD_W-1:0] CORDIC_START = CORD_W'(652032874);
	localparam logic signed [CORD_W-1:0] C_ONE = CORD_W'(ONE_Q30);
	localparam logic signed [CORD_W-1:0] C_MONE = -C_ONE;
	localparam logic signed [CORD_W-1:0] ATAN [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
		34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772, 34'sd166886,
		34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608,
		34'sd1304, 34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41, 34'sd20,
		34'sd10, 34'sd5, 34'sd3, 34'sd1
	};

	logic signed [CORD_W-1:0] x_q, y_q, z_q;
	logic signed [CORD_W-1:0] dx, dy;
	logic [STEP_W-1:0]        i_q;
	logic                     run_q;

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q   <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			i_q   <= '0;
		end else if (run_q) begin
			if (i_q == STEP_LAST) begin
				run_q <= 1'b0;
			end else begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;

	// One rotation step a cycle; the residual angle steers the direction.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_START;
			y_q <= '0;
			z_q <= CORD_W'(angle) <<< (31 - ANGLE_BITS);
		end else if (run_q) begin
			if (!z_q[CORD_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ATAN[i_q];
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ATAN[i_q];
			end
		end
	end

	// Clamp the results to the unit range.
	always_comb begin
		if (x_q > C_ONE) begin
			cos_h = UNIT_W'(ONE_Q30);
		end else if (x_q < C_MONE) begin
			cos_h = -UNIT_W'(ONE_Q30);
		end else begin
			cos_h = x_q[UNIT_W-1:0];
		end
		if (y_q > C_ONE) begin
			sin_h = UNIT_W'(ONE_Q30);
		end else if (y_q < C_MONE) begin
			sin_h = -UNIT_W'(ONE_Q30);
		end else begin
			sin_h = y_q[UNIT_W-1:0];
		end
	end

	assign sts.busy = run_q;
	assign sts.fin  = run_q && (i_q == STEP_LAST);

endmodule

// File: hdl/lfkj_mac.sv
// One multiply-accumulate lane with a registered product.
module lfkj_mac import lfkj_pkg::*; (
	input  logic                     clk,
	input  lfkj_lane_ctl_t           ctl,
	input  logic signed [OP_W-1:0]   a,
	input  logic signed [OP_W-1:0]   b,
	output logic signed [ACC_W-1:0]  sum
);

	logic signed [2*OP_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;

	// The accumulator trails the product register: it adds the registered product.
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_s1 <= a * b;
			if (ctl.load) begin
				acc_q <= ctl.diag ? ONE_Q60 : '0;
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	assign sum = acc_q + ACC_W'(prod_s1);

endmodule

// File: hdl/lfkj_chain.sv
// Chain sequencer: four lanes build frames, offsets, Jacobian columns and the pose.
module lfkj_chain import lfkj_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_ready,
	input  logic                src_mode,
	input  unit_t               cos_h [JOINT_COUNT],
	input  unit_t               sin_h [JOINT_COUNT],
	input  logic [LEN_W-1:0]    upper_len,
	input  logic [LEN_W-1:0]    lower_len,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [2:0]          column,
	output logic signed [LIN_W-1:0] lin_x,
	output logic signed [LIN_W-1:0] lin_y,
	output logic signed [LIN_W-1:0] lin_z,
	output unit_t               ang_x,
	output unit_t               ang_y,
	output unit_t               ang_z,
	output unit_t               ang_w,
	output logic                last
);

	localparam int LANES = 4;
	localparam logic [1:0] QW = 2'd0, QX = 2'd1, QY = 2'd2, QZ = 2'd3;
	localparam logic [1:0] AX_X = 2'd0, AX_Y = 2'd1, AX_Z = 2'd2;
	localparam logic [JNT_W-1:0] KNEE_JOINT  = JNT_W'(3);
	localparam logic [JNT_W-1:0] ANKLE_JOINT = JNT_W'(4);
	localparam logic [JNT_W-1:0] LAST_JOINT  = JNT_W'(JOINT_COUNT - 1);
	localparam logic [2:0] RCOL_LAST = 3'd2;
	localparam logic [2:0] OFFS_LAST = 3'd1;
	localparam logic [2:0] QMUL_LAST = 3'd4;
	localparam logic signed [RND_W-1:0] R_ONE  = RND_W'(ONE_Q30);
	localparam logic signed [RND_W-1:0] R_MONE = -R_ONE;
	localparam logic signed [RND_W-1:0] R_LIN  = RND_W'(LIN_LIMIT);
	localparam logic signed [RND_W-1:0] R_MLIN = -R_LIN;

	typedef struct packed {
		logic [1:0] ia;
		logic [1:0] ib;
		logic       neg;
	} rterm_t;

	// Round half up by 30 bits.
	function automatic logic signed [RND_W-1:0] round30(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = v + ACC_W'(HALF_Q30);
		return t[ACC_W-1:30];
	endfunction

	function automatic unit_t clamp_unit(input logic signed [RND_W-1:0] r);
		unit_t u;
		if (r > R_ONE) begin
			u = UNIT_W'(ONE_Q30);
		end else if (r < R_MONE) begin
			u = -UNIT_W'(ONE_Q30);
		end else begin
			u = r[UNIT_W-1:0];
		end
		return u;
	endfunction

	function automatic logic signed [LIN_W-1:0] sat_lin(input logic signed [RND_W-1:0] r);
		logic signed [LIN_W-1:0] v;
		if (r > R_LIN) begin
			v = LIN_W'(LIN_LIMIT);
		end else if (r < R_MLIN) begin
			v = -LIN_W'(LIN_LIMIT);
		end else begin
			v = r[LIN_W-1:0];
		end
		return v;
	endfunction

	// Local axis of each joint: Z, X, Y, Y, Y, X.
	function automatic logic [1:0] joint_axis(input logic [JNT_W-1:0] j);
		logic [1:0] k;
		case (j)
			3'd0: k = AX_Z;
			3'd2, 3'd3, 3'd4: k = AX_Y;
			default: k = AX_X;
		endcase
		return k;
	endfunction

	// Product terms of rotation matrix column k, entry e, term t.
	function automatic rterm_t rcol_term(input logic [1:0] k, input logic [1:0] e,
			input logic t);
		rterm_t r;
		case ({k, e, t})
			{AX_X, 2'd0, 1'b0}: r = '{QY, QY, 1'b1};
			{AX_X, 2'd0, 1'b1}: r = '{QZ, QZ, 1'b1};
			{AX_X, 2'd1, 1'b0}: r = '{QX, QY, 1'b0};
			{AX_X, 2'd1, 1'b1}: r = '{QW, QZ, 1'b0};
			{AX_X, 2'd2, 1'b0}: r = '{QX, QZ, 1'b0};
			{AX_X, 2'd2, 1'b1}: r = '{QW, QY, 1'b1};
			{AX_Y, 2'd0, 1'b0}: r = '{QX, QY, 1'b0};
			{AX_Y, 2'd0, 1'b1}: r = '{QW, QZ, 1'b1};
			{AX_Y, 2'd1, 1'b0}: r = '{QX, QX, 1'b1};
			{AX_Y, 2'd1, 1'b1}: r = '{QZ, QZ, 1'b1};
			{AX_Y, 2'd2, 1'b0}: r = '{QY, QZ, 1'b0};
			{AX_Y, 2'd2, 1'b1}: r = '{QW, QX, 1'b0};
			{AX_Z, 2'd0, 1'b0}: r = '{QX, QZ, 1'b0};
			{AX_Z, 2'd0, 1'b1}: r = '{QW, QY, 1'b0};
			{AX_Z, 2'd1, 1'b0}: r = '{QY, QZ, 1'b0};
			{AX_Z, 2'd1, 1'b1}: r = '{QW, QX, 1'b1};
			{AX_Z, 2'd2, 1'b0}: r = '{QX, QX, 1'b1};
			{AX_Z, 2'd2, 1'b1}: r = '{QY, QY, 1'b1};
			default: r = '{QW, QW, 1'b0};
		endcase
		return r;
	endfunction

	// Sign of term t of quaternion product component n.
	function automatic logic qneg(input logic [1:0] n, input logic [1:0] t);
		logic s;
		case (n)
			QW: s = (t != 2'd0);
			QX: s = (t == 2'd3);
			QY: s = (t == 2'd1);
			default: s = (t == 2'd2);
		endcase
		return s;
	endfunction

	function automatic logic [1:0] succ3(input logic [1:0] e);
		logic [1:0] r;
		case (e)
			2'd0: r = 2'd1;
			2'd1: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	lfkj_state_t state_q, state_d;
	logic [JNT_W-1:0] jnt_q, jnt_d;
	logic [2:0]       step_q, step_d;
	logic             lane_run, emit_col, emit_pose;
	logic             wr_axis, wr_zc, wr_off, wr_q;
	logic             out_ok;

	unit_t c_q [JOINT_COUNT];
	unit_t s_q [JOINT_COUNT];
	logic  mode_q;
	unit_t q_q [LANES];
	pos_t  p_q [3];
	unit_t zc_q [3];
	unit_t axis_q [JOINT_COUNT][3];
	pos_t  pos_q [JOINT_COUNT][3];

	lfkj_lane_ctl_t          lane_ctl [LANES];
	logic signed [OP_W-1:0]  lane_a [LANES];
	logic signed [OP_W-1:0]  lane_b [LANES];
	logic signed [ACC_W-1:0] lane_sum [LANES];
	logic signed [RND_W-1:0] rnd_sum [LANES];
	unit_t                   unit_sum [LANES];

	assign out_ok = !out_valid || !out_stall;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			jnt_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			jnt_q   <= jnt_d;
			step_q  <= step_d;
		end
	end

	// Next state and phase strobes.
	always_comb begin
		state_d   = state_q;
		jnt_d     = jnt_q;
		step_d    = step_q;
		src_ready = 1'b0;
		lane_run  = 1'b0;
		emit_col  = 1'b0;
		emit_pose = 1'b0;
		wr_axis   = 1'b0;
		wr_zc     = 1'b0;
		wr_off    = 1'b0;
		wr_q      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				src_ready = 1'b1;
				if (src_valid) begin
					state_d = ST_AXIS;
					jnt_d   = '0;
					step_d  = '0;
				end
			end
			ST_AXIS: begin
				lane_run = 1'b1;
				if (step_q == RCOL_LAST) begin
					wr_axis = 1'b1;
					step_d  = '0;
					if (jnt_q == KNEE_JOINT || jnt_q == ANKLE_JOINT) begin
						state_d = ST_ZCOL;
					end else begin
						state_d = ST_QMUL;
					end
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_ZCOL: begin
				lane_run = 1'b1;
				if (step_q == RCOL_LAST) begin
					wr_zc   = 1'b1;
					step_d  = '0;
					state_d = ST_OFFS;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_OFFS: begin
				lane_run = 1'b1;
				if (step_q == OFFS_LAST) begin
					wr_off  = 1'b1;
					step_d  = '0;
					state_d = ST_QMUL;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_QMUL: begin
				lane_run = 1'b1;
				if (step_q == QMUL_LAST) begin
					wr_q   = 1'b1;
					step_d = '0;
					if (jnt_q == LAST_JOINT) begin
						jnt_d   = '0;
						state_d = mode_q ? ST_CROSS : ST_POSE;
					end else begin
						jnt_d   = jnt_q + 1'b1;
						state_d = ST_AXIS;
					end
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_CROSS: begin
				if (step_q == RCOL_LAST) begin
					// Hold the lanes frozen until the output register is free.
					if (out_ok) begin
						lane_run = 1'b1;
						emit_col = 1'b1;
						step_d   = '0;
						if (jnt_q == LAST_JOINT) begin
							state_d = ST_POSE;
						end else begin
							jnt_d = jnt_q + 1'b1;
						end
					end
				end else begin
					lane_run = 1'b1;
					step_d   = step_q + 1'b1;
				end
			end
			ST_POSE: begin
				if (out_ok) begin
					emit_pose = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Lane operand selection for each phase.
	always_comb begin
		logic [1:0]             li, k, ti;
		rterm_t                 tm;
		logic signed [OP_W-1:0] base;
		unit_t                  rq [LANES];
		logic signed [DIF_W-1:0] d [3];
		logic [LEN_W-1:0]       len;
		k   = (state_q == ST_ZCOL) ? AX_Z : joint_axis(jnt_q);
		ti  = step_q[1:0];
		len = (jnt_q == KNEE_JOINT) ? upper_len : lower_len;
		for (int n = 0; n < LANES; n++) begin
			rq[n] = '0;
		end
		rq[0]          = c_q[jnt_q];
		rq[k + 2'd1]   = s_q[jnt_q];
		for (int e = 0; e < 3; e++) begin
			d[e] = DIF_W'(pos_q[LAST_JOINT][e]) - DIF_W'(pos_q[jnt_q][e]);
		end
		for (int l = 0; l < LANES; l++) begin
			li              = 2'(l);
			lane_ctl[l].en   = lane_run;
			lane_ctl[l].load = (step_q == 3'd0);
			lane_ctl[l].diag = 1'b0;
			lane_a[l]        = '0;
			lane_b[l]        = '0;
			tm               = rcol_term(k, li, step_q[0]);
			base             = OP_W'(q_q[tm.ia]) <<< 1;
			case (state_q)
				ST_AXIS, ST_ZCOL: begin
					if (l < 3) begin
						lane_a[l]        = tm.neg ? -base : base;
						lane_b[l]        = OP_W'(q_q[tm.ib]);
						lane_ctl[l].diag = (li == k);
					end
				end
				ST_OFFS: begin
					if (l < 3) begin
						lane_a[l] = OP_W'(zc_q[li]);
						lane_b[l] = OP_W'({1'b0, len});
					end
				end
				ST_QMUL: begin
					lane_a[l] = qneg(li, ti) ? -OP_W'(q_q[ti]) : OP_W'(q_q[ti]);
					lane_b[l] = OP_W'(rq[li ^ ti]);
				end
				ST_CROSS: begin
					if (l < 3) begin
						if (!step_q[0]) begin
							lane_a[l] = OP_W'(axis_q[jnt_q][succ3(li)]);
							lane_b[l] = OP_W'(d[succ3(succ3(li))]);
						end else begin
							lane_a[l] = -OP_W'(axis_q[jnt_q][succ3(succ3(li))]);
							lane_b[l] = OP_W'(d[succ3(li)]);
						end
					end
				end
				default: begin
					lane_a[l] = '0;
				end
			endcase
		end
	end

	// Four multiply-accumulate lanes.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		lfkj_mac u_mac (
			.clk (clk),
			.ctl (lane_ctl[g]),
			.a   (lane_a[g]),
			.b   (lane_b[g]),
			.sum (lane_sum[g])
		);
		assign rnd_sum[g]  = round30(lane_sum[g]);
		assign unit_sum[g] = clamp_unit(rnd_sum[g]);
	end

	// Merge lane results into the chain state.
	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			c_q    <= cos_h;
			s_q    <= sin_h;
			mode_q <= src_mode;
			q_q[0] <= UNIT_W'(ONE_Q30);
			q_q[1] <= '0;
			q_q[2] <= '0;
			q_q[3] <= '0;
			for (int e = 0; e < 3; e++) begin
				p_q[e] <= '0;
			end
		end
		for (int e = 0; e < 3; e++) begin
			if (wr_axis) begin
				axis_q[jnt_q][e] <= unit_sum[e];
			end
			if (wr_zc) begin
				zc_q[e] <= unit_sum[e];
			end
			if (wr_off) begin
				p_q[e] <= p_q[e] - rnd_sum[e][POS_W-1:0];
			end
			if (wr_q) begin
				pos_q[jnt_q][e] <= p_q[e];
			end
		end
		if (wr_q) begin
			for (int n = 0; n < LANES; n++) begin
				q_q[n] <= unit_sum[n];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit_col || emit_pose) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_col) begin
			column <= jnt_q;
			lin_x  <= sat_lin(rnd_sum[0]);
			lin_y  <= sat_lin(rnd_sum[1]);
			lin_z  <= sat_lin(rnd_sum[2]);
			ang_x  <= axis_q[jnt_q][0];
			ang_y  <= axis_q[jnt_q][1];
			ang_z  <= axis_q[jnt_q][2];
			ang_w  <= '0;
			last   <= 1'b0;
		end else if (emit_pose) begin
			column <= POSE_COLUMN;
			lin_x  <= sat_lin(RND_W'(pos_q[LAST_JOINT][0]));
			lin_y  <= sat_lin(RND_W'(pos_q[LAST_JOINT][1]));
			lin_z  <= sat_lin(RND_W'(pos_q[LAST_JOINT][2]));
			ang_x  <= q_q[1];
			ang_y  <= q_q[2];
			ang_z  <= q_q[3];
			ang_w  <= q_q[0];
			last   <= 1'b1;
		end
	end

endmodule

// File: hdl/leg_forward_kinematics_jacobian.sv
// Six-joint leg kinematics: six CORDIC lanes for the half angles run on an
// accepted set of joint angles, then a sequencer with four multiply-accumulate
// lanes walks the chain: per joint the world axis and the quaternion product,
// plus the link offsets at the knee and ankle, and in mode 1 one Jacobian
// column per joint after that, then the pose. The CORDIC lanes take the next
// item while the sequencer works, so the sequencer sets the pace of the items.
// With the sequencer free and no output stall, the first result is the pose in
// mode 0 and the first Jacobian column in mode 1. Results leave through an
// output register, so a stall on the output holds only the sequencer. Lengths
// may be written only while the block is idle.
module leg_forward_kinematics_jacobian import lfkj_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic signed [ANGLE_BITS-1:0] angle_0,
	input  logic signed [ANGLE_BITS-1:0] angle_1,
	input  logic signed [ANGLE_BITS-1:0] angle_2,
	input  logic signed [ANGLE_BITS-1:0] angle_3,
	input  logic signed [ANGLE_BITS-1:0] angle_4,
	input  logic signed [ANGLE_BITS-1:0] angle_5,
	input  logic                         wr_en,
	input  logic [IDX_W-1:0]             wr_index,
	input  logic [LEN_W-1:0]             wr_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   column,
	output logic signed [LIN_W-1:0]      lin_x,
	output logic signed [LIN_W-1:0]      lin_y,
	output logic signed [LIN_W-1:0]      lin_z,
	output unit_t                        ang_x,
	output unit_t                        ang_y,
	output unit_t                        ang_z,
	output unit_t                        ang_w,
	output logic                         last
);

	logic [LEN_W-1:0] upper_q, lower_q;
	logic             cord_full_q, mode_q;
	logic             accept, take, chain_ready;
	lfkj_cordic_sts_t lane_sts;
	logic signed [ANGLE_BITS-1:0] angle_in [JOINT_COUNT];
	unit_t cos_h [JOINT_COUNT];
	unit_t sin_h [JOINT_COUNT];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= LEN_W'(19661);
			lower_q <= LEN_W'(19661);
		end else if (wr_en) begin
			if (wr_index == REG_UPPER) begin
				upper_q <= wr_data;
			end else if (wr_index == REG_LOWER) begin
				lower_q <= wr_data;
			end
		end
	end

	// Input transfer starts the CORDIC lanes; their results wait for the sequencer.
	assign take     = cord_full_q && chain_ready;
	assign in_stall = lane_sts.busy || (cord_full_q && !chain_ready);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cord_full_q <= 1'b0;
		end else if (lane_sts.fin) begin
			cord_full_q <= 1'b1;
		end else if (take) begin
			cord_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
		end
	end

	assign angle_in[0] = angle_0;
	assign angle_in[1] = angle_1;
	assign angle_in[2] = angle_2;
	assign angle_in[3] = angle_3;
	assign angle_in[4] = angle_4;
	assign angle_in[5] = angle_5;

	// One CORDIC lane per joint; lane 0 reports for all.
	lfkj_cordic u_cordic0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.angle  (angle_in[0]),
		.cos_h  (cos_h[0]),
		.sin_h  (sin_h[0]),
		.sts    (lane_sts)
	);

	for (genvar g = 1; g < JOINT_COUNT; g++) begin : g_cordic
		lfkj_cordic u_cordic (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (accept),
			.angle  (angle_in[g]),
			.cos_h  (cos_h[g]),
			.sin_h  (sin_h[g]),
			.sts    ()
		);
	end

	// Chain sequencer and output register.
	lfkj_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (cord_full_q),
		.src_ready (chain_ready),
		.src_mode  (mode_q),
		.cos_h     (cos_h),
		.sin_h     (sin_h),
		.upper_len (upper_q),
		.lower_len (lower_q),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.column    (column),
		.lin_x     (lin_x),
		.lin_y     (lin_y),
		.lin_z     (lin_z),
		.ang_x     (ang_x),
		.ang_y     (ang_y),
		.ang_z     (ang_z),
		.ang_w     (ang_w),
		.last      (last)
	);

endmodule

// File: hdl/lfkj_checker.sv
// Port-level checks of the leg kinematics block and their binding.
module lfkj_checker import lfkj_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         mode,
	input logic signed [ANGLE_BITS-1:0] angle_0,
	input logic signed [ANGLE_BITS-1:0] angle_1,
	input logic signed [ANGLE_BITS-1:0] angle_2,
	input logic signed [ANGLE_BITS-1:0] angle_3,
	input logic signed [ANGLE_BITS-1:0] angle_4,
	input logic signed [ANGLE_BITS-1:0] angle_5,
	input logic                         wr_en,
	input logic [IDX_W-1:0]             wr_index,
	input logic [LEN_W-1:0]             wr_data,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [2:0]                   column,
	input logic signed [LIN_W-1:0]      lin_x,
	input logic signed [LIN_W-1:0]      lin_y,
	input logic signed [LIN_W-1:0]      lin_z,
	input unit_t                        ang_x,
	input unit_t                        ang_y,
	input unit_t                        ang_z,
	input unit_t                        ang_w,
	input logic                         last
);

	localparam logic signed [LIN_W-1:0] LIN_HI = LIN_W'(LIN_LIMIT);
	localparam logic signed [LIN_W-1:0] LIN_LO = -LIN_HI;

	// A stalled result stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(column) && $stable(lin_x)
			&& $stable(ang_w) && $stable(last))
		else $error("result changed while stalled");

	// The pose, and only the pose, ends a run.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (column == POSE_COLUMN)))
		else $error("last flag does not match column code");

	// Jacobian columns carry no scalar part.
	a_colw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> ang_w == '0)
		else $error("column result with nonzero scalar part");

	// Linear parts stay within the saturation limits.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lin_x <= LIN_HI && lin_x >= LIN_LO && lin_y <= LIN_HI
			&& lin_y >= LIN_LO && lin_z <= LIN_HI && lin_z >= LIN_LO)
		else $error("linear result beyond saturation limit");

endmodule

bind leg_forward_kinematics_jacobian lfkj_checker u_lfkj_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench of the leg forward kinematics and Jacobian block.
module tb_top;
	import lfkj_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam longint CORDIC_START = 652032874;
	localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1};
	// Local rotation axis per joint: 0 is X, 1 is Y, 2 is Z.
	localparam int JOINT_AXIS [JOINT_COUNT] = '{2, 0, 1, 1, 1, 0};

	typedef struct {
		logic [2:0]       column;
		logic [LIN_W-1:0] lin [3];
		unit_t            ang [4];
		logic             last;
	} leg_result_t;

	typedef logic signed [ANGLE_BITS-1:0] joint_set_t [JOINT_COUNT];

	// Round half up by 30 fraction bits.
	function automatic longint round30(longint v);
		return (v + HALF_Q30) >>> 30;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint to_unit(longint v);
		return clip(round30(v), -ONE_Q30, ONE_Q30);
	endfunction

	// Half-angle cosine and sine by rotation-mode CORDIC.
	function automatic void half_sincos(input longint z, output longint c, output longint s);
		longint x, y, dx, dy;
		x = CORDIC_START;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TURNS[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TURNS[i];
			end
		end
		c = clip(x, -ONE_Q30, ONE_Q30);
		s = clip(y, -ONE_Q30, ONE_Q30);
	endfunction

	// Quaternion product p = p * r, components ordered w, x, y, z.
	function automatic void quat_mul(inout longint p [4], input longint r [4]);
		longint w, x, y, z;
		w = p[0]*r[0] - p[1]*r[1] - p[2]*r[2] - p[3]*r[3];
		x = p[0]*r[1] + p[1]*r[0] + p[2]*r[3] - p[3]*r[2];
		y = p[0]*r[2] - p[1]*r[3] + p[2]*r[0] + p[3]*r[1];
		z = p[0]*r[3] + p[1]*r[2] - p[2]*r[1] + p[3]*r[0];
		p[0] = to_unit(w); p[1] = to_unit(x); p[2] = to_unit(y); p[3] = to_unit(z);
	endfunction

	// Column k of the rotation matrix of quaternion q.
	function automatic void rot_column(input longint q [4], input int k, output longint c [3]);
		longint w, x, y, z, one;
		w = q[0]; x = q[1]; y = q[2]; z = q[3];
		one = 64'sd1 << 60;
		if (k == 0) begin
			c[0] = one - 2*(y*y + z*z); c[1] = 2*(x*y + w*z); c[2] = 2*(x*z - w*y);
		end else if (k == 1) begin
			c[0] = 2*(x*y - w*z); c[1] = one - 2*(x*x + z*z); c[2] = 2*(y*z + w*x);
		end else begin
			c[0] = 2*(x*z + w*y); c[1] = 2*(y*z - w*x); c[2] = one - 2*(x*x + y*y);
		end
		for (int j = 0; j < 3; j++) c[j] = to_unit(c[j]);
	endfunction

	// Scoreboard: predicts the columns and pose of each transfer in and checks results.
	class leg_scoreboard;
		longint      thigh_len = 19661;
		longint      shank_len = 19661;
		leg_result_t pending [$];
		int          mismatches = 0;

		function void add_result(int col, longint v [3], longint a [4], logic fin);
			leg_result_t r;
			r.column = col[2:0];
			for (int j = 0; j < 3; j++) r.lin[j] = LIN_W'(clip(v[j], -LIN_LIMIT, LIN_LIMIT));
			for (int j = 0; j < 4; j++) r.ang[j] = unit_t'(a[j]);
			r.last = fin;
			pending.push_back(r);
		endfunction

		function void note_joint_set(logic jac, joint_set_t jset);
			longint q [4], rq [4], axis [JOINT_COUNT][3], pos [JOINT_COUNT][3];
			longint p [3], zc [3], ac [3], d [3], v [3], a [4], len, c, s;
			q = '{ONE_Q30, 0, 0, 0};
			p = '{0, 0, 0};
			for (int i = 0; i < JOINT_COUNT; i++) begin
				rot_column(q, JOINT_AXIS[i], ac);
				axis[i] = ac;
				len = (i == 3) ? thigh_len : (i == 4) ? shank_len : 0;
				if (len != 0) begin
					rot_column(q, 2, zc);
					for (int j = 0; j < 3; j++) p[j] -= round30(len * zc[j]);
				end
				pos[i] = p;
				half_sincos(longint'(jset[i]) * (64'sd1 << (31 - ANGLE_BITS)), c, s);
				rq = '{c, 0, 0, 0};
				rq[1 + JOINT_AXIS[i]] = s;
				quat_mul(q, rq);
			end
			if (jac) begin
				for (int i = 0; i < JOINT_COUNT; i++) begin
					for (int j = 0; j < 3; j++) d[j] = pos[JOINT_COUNT-1][j] - pos[i][j];
					v[0] = round30(axis[i][1]*d[2] - axis[i][2]*d[1]);
					v[1] = round30(axis[i][2]*d[0] - axis[i][0]*d[2]);
					v[2] = round30(axis[i][0]*d[1] - axis[i][1]*d[0]);
					a = '{axis[i][0], axis[i][1], axis[i][2], 0};
					add_result(i, v, a, 1'b0);
				end
			end
			a = '{q[1], q[2], q[3], q[0]};
			add_result(POSE_COLUMN, pos[JOINT_COUNT-1], a, 1'b1);
		endfunction

		function void check_result(leg_result_t got);
			leg_result_t exp_r;
			bit bad;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: column %0d", got.column);
				return;
			end
			exp_r = pending.pop_front();
			bad = (got.column !== exp_r.column) || (got.last !== exp_r.last);
			for (int j = 0; j < 3; j++) bad |= (got.lin[j] !== exp_r.lin[j]);
			for (int j = 0; j < 4; j++) bad |= (got.ang[j] !== exp_r.ang[j]);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected col %0d lin %0d %0d %0d ang %0d %0d %0d %0d last %0b",
						exp_r.column, $signed(exp_r.lin[0]), $signed(exp_r.lin[1]),
						$signed(exp_r.lin[2]), exp_r.ang[0], exp_r.ang[1], exp_r.ang[2],
						exp_r.ang[3], exp_r.last);
					$display("          actual   col %0d lin %0d %0d %0d ang %0d %0d %0d %0d last %0b",
						got.column, $signed(got.lin[0]), $signed(got.lin[1]),
						$signed(got.lin[2]), got.ang[0], got.ang[1], got.ang[2],
						got.ang[3], got.last);
				end
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, mode;
	logic signed [ANGLE_BITS-1:0] angle_0, angle_1, angle_2, angle_3, angle_4, angle_5;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [LEN_W-1:0] wr_data;
	logic out_valid, out_stall, last;
	logic [2:0] column;
	logic signed [LIN_W-1:0] lin_x, lin_y, lin_z;
	unit_t ang_x, ang_y, ang_z, ang_w;

	leg_scoreboard kin_board = new();
	bit steady_flow = 0;

	leg_forward_kinematics_jacobian dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Generous limit on the whole run.
	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int draw_gap();
		return steady_flow ? 0 : $urandom_range(0, 8);
	endfunction

	task automatic write_length(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] val);
		@(negedge clk);
		wr_en = 1; wr_index = idx; wr_data = val;
		@(negedge clk);
		wr_en = 0;
		if (idx == REG_UPPER) kin_board.thigh_len = val;
		else if (idx == REG_LOWER) kin_board.shank_len = val;
	endtask

	// One joint set transfer, after a random gap unless steady_flow is set; leaves the call at a rising edge.
	task automatic send_joint_set(logic jac, joint_set_t jset);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1; mode = jac;
		angle_0 = jset[0]; angle_1 = jset[1]; angle_2 = jset[2];
		angle_3 = jset[3]; angle_4 = jset[4]; angle_5 = jset[5];
		do @(posedge clk); while (in_stall);
		kin_board.note_joint_set(jac, jset);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (kin_board.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic send_random(int count);
		joint_set_t jset;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < JOINT_COUNT; i++) jset[i] = ANGLE_BITS'($urandom());
			send_joint_set(1'($urandom_range(0, 1)), jset);
		end
	endtask

	// Result side: random stalls, then wait for one transfer and check it.
	initial begin
		leg_result_t got;
		int gap;
		out_stall = 1;
		@(negedge clk);
		forever begin
			gap = draw_gap();
			out_stall = 1;
			repeat (gap) @(negedge clk);
			out_stall = 0;
			do @(posedge clk); while (!out_valid);
			got.column = column; got.last = last;
			got.lin[0] = lin_x; got.lin[1] = lin_y; got.lin[2] = lin_z;
			got.ang[0] = ang_x; got.ang[1] = ang_y; got.ang[2] = ang_z; got.ang[3] = ang_w;
			kin_board.check_result(got);
			@(negedge clk);
		end
	end

	// Stimulus: directed sets, then random phases across several lengths.
	initial begin
		joint_set_t jset;
		logic signed [ANGLE_BITS-1:0] corner [5];
		corner = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000, 16'shc000};
		arst_n = 0; in_valid = 0; mode = 0; wr_en = 0; wr_index = '0; wr_data = '0;
		angle_0 = 0; angle_1 = 0; angle_2 = 0; angle_3 = 0; angle_4 = 0; angle_5 = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Corner angles in both modes with the reset lengths.
		for (int k = 0; k < 5; k++) begin
			for (int i = 0; i < JOINT_COUNT; i++) jset[i] = corner[(k + i) % 5];
			send_joint_set(k[0], jset);
			for (int i = 0; i < JOINT_COUNT; i++) jset[i] = corner[k];
			send_joint_set(~k[0], jset);
		end
		drain();

		// Unused register indexes must leave the lengths alone.
		write_length(REG_SPARE_A, LEN_W'($urandom()));
		write_length(REG_SPARE_B, LEN_W'($urandom()));
		send_random(4);
		drain();

		// Largest lengths drive the foot position into saturation.
		write_length(REG_UPPER, '1);
		write_length(REG_LOWER, '1);
		for (int i = 0; i < JOINT_COUNT; i++) jset[i] = '0;
		send_joint_set(1'b1, jset);
		send_joint_set(1'b0, jset);
		steady_flow = 1;
		send_random(30);
		steady_flow = 0;
		drain();

		// Zero lengths and then lengths of 1048576, half the register range.
		write_length(REG_UPPER, '0);
		write_length(REG_LOWER, '0);
		send_random(30);
		drain();
		write_length(REG_UPPER, 21'd1048576);
		write_length(REG_LOWER, 21'd1048576);
		send_random(30);
		drain();

		// Mixed realistic lengths.
		write_length(REG_UPPER, LEN_W'($urandom_range(0, 2097151)));
		write_length(REG_LOWER, LEN_W'($urandom_range(0, 2097151)));
		send_random(25);
		drain();
		write_length(REG_UPPER, LEN_W'($urandom_range(10000, 40000)));
		write_length(REG_LOWER, LEN_W'($urandom_range(10000, 40000)));
		send_random(30);
		drain();

		if (kin_board.mismatches == 0 && kin_board.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/lfkj_pkg.sv
hdl/lfkj_cordic.sv
hdl/lfkj_mac.sv
hdl/lfkj_chain.sv
hdl/leg_forward_kinematics_jacobian.sv
hdl/lfkj_checker.sv
tb/tb_top.sv
